FILE: hdl/puc_pkg.sv
`default_nettype none

package puc_pkg;

  localparam int ITEMS_DEFAULT = 8;

  // Field widths of the two channels.
  localparam int OP_W     = 1;
  localparam int SLOT_W   = 3;
  localparam int VALUE_W  = 16;
  localparam int DIST_W   = 16;
  localparam int POS_W    = 3;
  localparam int CHOSEN_W = 3;

  localparam logic [OP_W-1:0] OP_LOAD    = 1'b0;
  localparam logic [OP_W-1:0] OP_ADVANCE = 1'b1;

  // Reciprocal scaling for the divide-by-radix in each cell. The sum that a cell
  // divides stays below 2^17 and the radix below 2^5, so 22 fraction bits are exact.
  localparam int RECIP_SHIFT = 22;

  // Carry that moves from one digit cell to the next more significant one.
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] carry;
  } puc_link_t;

endpackage

`default_nettype wire

FILE: hdl/puc_in_if.sv
`default_nettype none

interface puc_in_if import puc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [SLOT_W-1:0]  slot;
  logic [VALUE_W-1:0] value;
  logic [DIST_W-1:0]  distance;

  modport source (output valid, op, slot, value, distance, input ready);
  modport sink   (input valid, op, slot, value, distance, output ready);
endinterface

`default_nettype wire

FILE: hdl/puc_out_if.sv
`default_nettype none

interface puc_out_if import puc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [POS_W-1:0]    out_position;
  logic [CHOSEN_W-1:0] chosen_index;
  logic [VALUE_W-1:0]  chosen_value;
  logic                last;
  logic                exhausted;

  modport source (output valid, out_position, chosen_index, chosen_value, last, exhausted,
                  input ready);
  modport sink   (input valid, out_position, chosen_index, chosen_value, last, exhausted,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/puc_cell.sv
`default_nettype none

module puc_cell import puc_pkg::*; #(
  parameter int RADIX = 2,
  parameter int DIG_W = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  puc_link_t        link_in,
  output puc_link_t        link_out,
  output logic [DIG_W-1:0] digit
);

  localparam int T_W   = DIST_W + 1;
  localparam int MUL_W = RECIP_SHIFT + 1;
  localparam int P_W   = T_W + MUL_W;
  localparam longint unsigned MULT = ((longint'(1) << RECIP_SHIFT) + RADIX - 1) / RADIX;
  localparam logic [MUL_W-1:0] MULT_V = MUL_W'(MULT);

  logic [T_W-1:0] total;
  logic [P_W-1:0] prod;
  logic [T_W-1:0] quo;
  logic [T_W-1:0] rem;

  // Digit plus incoming carry, split into the new digit and the carry upward.
  always_comb begin
    total = T_W'(digit) + T_W'(link_in.carry);
    prod  = P_W'(total) * P_W'(MULT_V);
    quo   = prod[RECIP_SHIFT +: T_W];
    rem   = total - (quo * T_W'(RADIX));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.valid <= 1'b0;
      digit          <= '0;
    end else begin
      link_out.valid <= link_in.valid;
      if (link_in.valid) begin
        digit          <= DIG_W'(rem);
        link_out.carry <= DIST_W'(quo);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/puc_select.sv
`default_nettype none

module puc_select import puc_pkg::*; #(
  parameter int ITEMS = ITEMS_DEFAULT,
  parameter int IDX_W = 3
) (
  input  logic [ITEMS-1:0] used,
  input  logic [IDX_W-1:0] rank_digit,
  output logic [IDX_W-1:0] index
);

  logic [ITEMS-1:0] free;
  logic [ITEMS-1:0] below;

  // Each free position checks on its own whether exactly rank_digit free
  // positions lie below it; only one can match.
  always_comb begin
    free  = ~used;
    below = '0;
    index = '0;
    for (int j = 0; j < ITEMS; j++) begin
      below = '0;
      for (int m = 0; m < j; m++) begin
        below[m] = free[m];
      end
      if (free[j] && ($countones(below) == int'(rank_digit))) begin
        index = index | IDX_W'(j);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/permutation_unrank_stepper.sv
// Channel  Dir  Fields                                                    Accepted when
// cmd      in   op, slot, value, distance                                 cmd.valid & cmd.ready
// result   out  out_position, chosen_index, chosen_value, last, exhausted result.valid & result.ready
//
// A load item writes its table slot and gives no result. An advance item passes through the carry input register,
// ripples its distance through the row of ITEMS digit cells, one cell per cycle, then is checked
// for overflow as it leaves cell 0, then gives ITEMS results at one per cycle while the result
// channel does not stall. An advance item that overflows the rank gives a single exhausted result.
// An advance item after the rank has saturated gives its single result without rippling.
// Reset (rst, synchronous) clears the rank and the saturation flag; table slots hold
// nothing defined until loaded. A stalled result holds its register and the emission.
`default_nettype none

module permutation_unrank_stepper import puc_pkg::*; #(
  parameter int ITEMS = ITEMS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  puc_in_if.sink    cmd,
  puc_out_if.source result
);

  localparam int IDX_W = (ITEMS > 1) ? $clog2(ITEMS) : 1;
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(ITEMS - 1);

  typedef enum logic [1:0] {S_IDLE, S_RIPPLE, S_EXH, S_EMIT} state_t;

  state_t             state;
  logic               exh;
  puc_link_t          inject;
  puc_link_t          link [ITEMS];
  logic [IDX_W-1:0]   digit [ITEMS];
  logic [IDX_W-1:0]   pos;
  logic [ITEMS-1:0]   used;
  logic [IDX_W-1:0]   sel_idx;
  logic [VALUE_W-1:0] vtab [ITEMS];

  logic                res_valid;
  logic [POS_W-1:0]    res_pos;
  logic [CHOSEN_W-1:0] res_idx;
  logic [VALUE_W-1:0]  res_value;
  logic                res_last;
  logic                res_exh;

  logic accept;
  logic out_free;
  logic res_load;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign out_free  = !res_valid || result.ready;
  assign res_load  = out_free && ((state == S_EXH) || (state == S_EMIT));

  assign result.valid        = res_valid;
  assign result.out_position = res_pos;
  assign result.chosen_index = res_idx;
  assign result.chosen_value = res_value;
  assign result.last         = res_last;
  assign result.exhausted    = res_exh;

  // Cell i holds the factorial digit of position i, radix ITEMS-i. The carry enters at
  // the least significant cell and leaves at cell 0 as the overflow.
  for (genvar i = 0; i < ITEMS; i++) begin : g_cell
    if (i == ITEMS - 1) begin : g_tail
      puc_cell #(.RADIX(ITEMS - i), .DIG_W(IDX_W)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .link_in (inject),
        .link_out(link[i]),
        .digit   (digit[i])
      );
    end else begin : g_body
      puc_cell #(.RADIX(ITEMS - i), .DIG_W(IDX_W)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .link_in (link[i+1]),
        .link_out(link[i]),
        .digit   (digit[i])
      );
    end
  end

  puc_select #(.ITEMS(ITEMS), .IDX_W(IDX_W)) u_select (
    .used      (used),
    .rank_digit(digit[pos]),
    .index     (sel_idx)
  );

  always_ff @(posedge clk) begin
    if (accept && (cmd.op == OP_LOAD) && (int'(cmd.slot) < ITEMS)) begin
      vtab[IDX_W'(cmd.slot)] <= cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      exh          <= 1'b0;
      inject.valid <= 1'b0;
      res_valid    <= 1'b0;
      pos          <= '0;
      used         <= '0;
    end else begin
      inject.valid <= accept && (cmd.op == OP_ADVANCE) && !exh;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (cmd.op == OP_ADVANCE)) begin
            if (exh) begin
              state <= S_EXH;
            end else begin
              inject.carry <= cmd.distance;
              state        <= S_RIPPLE;
            end
          end
        end
        S_RIPPLE: begin
          // Any carry out of the top digit means the rank reached ITEMS!.
          if (link[0].valid) begin
            if (link[0].carry != '0) begin
              exh   <= 1'b1;
              state <= S_EXH;
            end else begin
              used  <= '0;
              pos   <= '0;
              state <= S_EMIT;
            end
          end
        end
        S_EXH: begin
          if (out_free) begin
            res_pos   <= '0;
            res_idx   <= '0;
            res_value <= '0;
            res_last  <= 1'b1;
            res_exh   <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            res_pos   <= POS_W'(pos);
            res_idx   <= CHOSEN_W'(sel_idx);
            res_value <= vtab[sel_idx];
            res_last  <= (pos == LAST_POS);
            res_exh   <= 1'b0;
            used      <= used | (ITEMS'(1) << sel_idx);
            pos       <= pos + 1'b1;
            if (pos == LAST_POS) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/puc_checker.sv
`default_nettype none

module puc_checker import puc_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_ready,
  input logic [OP_W-1:0]     cmd_op,
  input logic                res_valid,
  input logic                res_ready,
  input logic [POS_W-1:0]    res_pos,
  input logic [CHOSEN_W-1:0] res_idx,
  input logic [VALUE_W-1:0]  res_value,
  input logic                res_last,
  input logic                res_exh
);

  // A pending result is not withdrawn.
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result valid dropped while stalled");

  // A stalled result keeps its payload.
  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=>
      $stable(res_pos) && $stable(res_idx) && $stable(res_value) &&
      $stable(res_last) && $stable(res_exh))
    else $error("result payload changed while stalled");

  // The saturated result is a single, all-zero, final item.
  a_exh_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_exh |->
      res_last && (res_pos == '0) && (res_idx == '0) && (res_value == '0))
    else $error("exhausted result with unexpected fields");

  // No new item is taken while a permutation is still being given out.
  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last |-> !cmd_ready)
    else $error("item accepted in the middle of a permutation");

  // A load item gives no result.
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd_op == OP_LOAD) && !res_valid |=> !res_valid)
    else $error("load item produced a result");

endmodule

bind permutation_unrank_stepper puc_checker u_puc_checker (
  .clk      (clk),
  .rst      (rst),
  .cmd_valid(cmd.valid),
  .cmd_ready(cmd.ready),
  .cmd_op   (cmd.op),
  .res_valid(result.valid),
  .res_ready(result.ready),
  .res_pos  (result.out_position),
  .res_idx  (result.chosen_index),
  .res_value(result.chosen_value),
  .res_last (result.last),
  .res_exh  (result.exhausted)
);

`default_nettype wire
